@@ rtl/core/scr_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the stereo comb reverb.
// Used by every module of the block; depends on nothing.
package scr_pkg;

  localparam int DATA_W       = 32;
  localparam int SAMPLE_W     = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int ATTN_W       = 3;
  localparam int LEN_A_W      = 15;
  localparam int LEN_B_W      = 15;
  localparam int LEN_C_W      = 14;
  localparam int LEN_D_W      = 13;

  localparam int LINE_A_DEPTH_DEF = 16384;
  localparam int LINE_B_DEPTH_DEF = 16384;
  localparam int LINE_C_DEPTH_DEF = 8192;
  localparam int LINE_D_DEPTH_DEF = 4096;

  localparam int HP_DLY_DEPTH = 32;
  localparam int HP_AVG_DEPTH = 64;
  localparam int LP_DEPTH     = 8;

  localparam logic [ATTN_W-1:0]  ATTN_RESET  = 3'd3;
  localparam logic [LEN_A_W-1:0] LEN_A_RESET = 15'd441;
  localparam logic [LEN_B_W-1:0] LEN_B_RESET = 15'd337;
  localparam logic [LEN_C_W-1:0] LEN_C_RESET = 14'd237;
  localparam logic [LEN_D_W-1:0] LEN_D_RESET = 13'd162;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE = 3'd0,
    CFG_ATTN   = 3'd1,
    CFG_LEN_A  = 3'd2,
    CFG_LEN_B  = 3'd3,
    CFG_LEN_C  = 3'd4,
    CFG_LEN_D  = 3'd5
  } scr_cfg_e;

  // Per-request control shared by all storage units.
  typedef struct packed {
    logic clr;  // configuration write, return to the cleared state
    logic rd;   // request accepted with reverb on, read and advance
    logic wr;   // request leaves the compute stage with reverb on, write back
  } scr_ctrl_t;

  // Arithmetic right shift of a 32-bit word.
  function automatic logic [DATA_W-1:0] asr32(input logic [DATA_W-1:0] u,
                                              input logic [ATTN_W-1:0] s);
    logic signed [DATA_W-1:0] t;
    t = signed'(u);
    return DATA_W'(t >>> s);
  endfunction

endpackage

@@ rtl/core/stereo_comb_reverb.sv @@
`timescale 1ns / 1ps
// Stereo comb reverb. An accepted request goes through one compute stage, which feeds
// the output register that drives the outputs.
// Throughput: one request per cycle while the output is not stalled; each delay line memory
// takes one read at acceptance and one write when the request leaves the compute stage.
// Reset is asynchronous and active low; it and every write to a listed register clear all
// positions, sums and fill flags at once, so no memory clearing pass is needed.
module stereo_comb_reverb import scr_pkg::*; #(
  parameter int LINE_A_DEPTH = LINE_A_DEPTH_DEF,
  parameter int LINE_B_DEPTH = LINE_B_DEPTH_DEF,
  parameter int LINE_C_DEPTH = LINE_C_DEPTH_DEF,
  parameter int LINE_D_DEPTH = LINE_D_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration write channel.
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  // Sample input channel.
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] first_channel_in_i,
  input  logic signed [SAMPLE_W-1:0] second_channel_in_i,
  input  logic                       block_end_in_i,
  // Sample output channel.
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] first_channel_out_o,
  output logic signed [SAMPLE_W-1:0] second_channel_out_o,
  output logic                       block_end_out_o
);

  // Configuration registers. The port never stalls a write.
  logic               enable_q;
  logic [ATTN_W-1:0]  attn_q;
  logic [LEN_A_W-1:0] len_a_q;
  logic [LEN_B_W-1:0] len_b_q;
  logic [LEN_C_W-1:0] len_c_q;
  logic [LEN_D_W-1:0] len_d_q;
  logic               cfg_hit;

  assign cfg_ready_o = 1'b1;

  // Only writes to a register in the list clear the reverb state.
  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ENABLE, CFG_ATTN, CFG_LEN_A,
        CFG_LEN_B, CFG_LEN_C, CFG_LEN_D: cfg_hit = 1'b1;
        default:                         cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
      attn_q   <= ATTN_RESET;
      len_a_q  <= LEN_A_RESET;
      len_b_q  <= LEN_B_RESET;
      len_c_q  <= LEN_C_RESET;
      len_d_q  <= LEN_D_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ENABLE: enable_q <= cfg_data_i[0];
        CFG_ATTN:   attn_q   <= cfg_data_i[ATTN_W-1:0];
        CFG_LEN_A:  len_a_q  <= cfg_data_i[LEN_A_W-1:0];
        CFG_LEN_B:  len_b_q  <= cfg_data_i[LEN_B_W-1:0];
        CFG_LEN_C:  len_c_q  <= cfg_data_i[LEN_C_W-1:0];
        CFG_LEN_D:  len_d_q  <= cfg_data_i[LEN_D_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake. The compute stage holds one request; it moves into the output
  // register whenever that register is empty or being drained, so a new request
  // is accepted in the same cycle as the held one moves on, or while the stage is empty.
  logic s1_valid_q, s1_go, in_acc;
  logic out_valid_q;

  assign s1_go       = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_go;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  scr_ctrl_t ctrl;
  assign ctrl.clr = cfg_hit;
  assign ctrl.rd  = in_acc && enable_q;
  assign ctrl.wr  = s1_go && enable_q;

  // Compute stage input register.
  logic signed [SAMPLE_W-1:0] x0_q, x1_q;
  logic                       end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x0_q  <= first_channel_in_i;
      x1_q  <= second_channel_in_i;
      end_q <= block_end_in_i;
    end
  end

  // The four delay lines. Each read is issued at acceptance and lands in the
  // compute stage; each write happens as the request leaves that stage.
  logic [DATA_W-1:0] tap_a, tap_b, tap_c, tap_d;
  logic [DATA_W-1:0] v_cd, vlp;

  scr_line #(.DEPTH(LINE_A_DEPTH), .LEN_W(LEN_A_W)) u_line_a (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .len_i(len_a_q), .wdata_i(vlp), .rdata_o(tap_a)
  );
  scr_line #(.DEPTH(LINE_B_DEPTH), .LEN_W(LEN_B_W)) u_line_b (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .len_i(len_b_q), .wdata_i(vlp), .rdata_o(tap_b)
  );
  scr_line #(.DEPTH(LINE_C_DEPTH), .LEN_W(LEN_C_W)) u_line_c (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .len_i(len_c_q), .wdata_i(v_cd), .rdata_o(tap_c)
  );
  scr_line #(.DEPTH(LINE_D_DEPTH), .LEN_W(LEN_D_W)) u_line_d (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .len_i(len_d_q), .wdata_i(v_cd), .rdata_o(tap_d)
  );

  // The summed echo goes through the high-pass filter.
  logic [DATA_W-1:0] echo, echodly;

  assign echo = tap_a + tap_b + tap_c + tap_d;

  scr_hpf u_hpf (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .echo_i(echo), .echodly_o(echodly)
  );

  // Feedback path: attenuated mono input plus echo into lines c and d, then an
  // eight-tap moving average of that mix plus an eighth of the echo into lines a and b.
  localparam int LP_AW = $clog2(LP_DEPTH);

  logic [DATA_W-1:0] lp_store_q [LP_DEPTH];
  logic [DATA_W-1:0] lp_sum_q, lp_sum_d;
  logic [LP_AW-1:0]  lp_pos_q;
  logic [DATA_W-1:0] mono, v_ab;
  logic [SAMPLE_W:0] mono_sum;

  always_comb begin
    mono_sum = {x0_q[SAMPLE_W-1], x0_q} + {x1_q[SAMPLE_W-1], x1_q};
    mono     = DATA_W'(signed'(mono_sum));
    v_cd     = asr32(mono, attn_q) + asr32(echodly, 3'd2);
    v_ab     = asr32(v_cd + asr32(echodly, 3'd3), 3'd1);
    lp_sum_d = lp_sum_q - lp_store_q[lp_pos_q] + v_ab;
    vlp      = asr32(lp_sum_d, 3'd2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_sum_q <= '0;
      lp_pos_q <= '0;
      for (int i = 0; i < LP_DEPTH; i++) begin
        lp_store_q[i] <= '0;
      end
    end else if (ctrl.clr) begin
      lp_sum_q <= '0;
      lp_pos_q <= '0;
      for (int i = 0; i < LP_DEPTH; i++) begin
        lp_store_q[i] <= '0;
      end
    end else if (ctrl.wr) begin
      lp_sum_q             <= lp_sum_d;
      lp_pos_q             <= lp_pos_q + 1'b1;
      lp_store_q[lp_pos_q] <= v_ab;
    end
  end

  // Output: each channel plus the filtered echo, saturated to 16 bits. With the
  // reverb off the samples pass through untouched and no state moves.
  function automatic logic [SAMPLE_W-1:0] sat16(input logic signed [SAMPLE_W-1:0] x,
                                                input logic [DATA_W-1:0] e);
    logic signed [DATA_W:0] s;
    s = (DATA_W+1)'(signed'(x)) + signed'({e[DATA_W-1], e});
    if (s > (DATA_W+1)'(32767)) begin
      return SAMPLE_W'(16'h7FFF);
    end else if (s < -(DATA_W+1)'(32768)) begin
      return SAMPLE_W'(16'h8000);
    end
    return s[SAMPLE_W-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      block_end_out_o <= end_q;
      if (enable_q) begin
        first_channel_out_o  <= sat16(x0_q, echodly);
        second_channel_out_o <= sat16(x1_q, echodly);
      end else begin
        first_channel_out_o  <= x0_q;
        second_channel_out_o <= x1_q;
      end
    end
  end

endmodule

@@ rtl/core/scr_line.sv @@
`timescale 1ns / 1ps
// One circular feedback delay line with its position counter and fill flag.
// Depends on scr_pkg for the control struct and widths.
module scr_line import scr_pkg::*; #(
  parameter int DEPTH = LINE_A_DEPTH_DEF,
  parameter int LEN_W = LEN_A_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scr_ctrl_t         ctrl_i,
  input  logic [LEN_W-1:0]  len_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  localparam int AW = $clog2(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] mem_rd_q;
  logic [DATA_W-1:0] fwd_data_q;
  logic [AW-1:0]     pos_q, pos_d;
  logic [AW-1:0]     addr_q;
  logic              wrap_q, fill_q, fwd_q;
  logic [AW:0]       pos_nxt;
  logic              pos_wrap;

  // The line runs over min(len, DEPTH) entries; a zero length keeps it at entry 0.
  always_comb begin
    pos_nxt  = (AW+1)'(pos_q) + (AW+1)'(1);
    pos_wrap = (32'(pos_nxt) >= 32'(len_i)) || (32'(pos_nxt) >= 32'(DEPTH));
    pos_d    = pos_wrap ? '0 : pos_nxt[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      wrap_q <= 1'b0;
      fill_q <= 1'b0;
      fwd_q  <= 1'b0;
    end else if (ctrl_i.clr) begin
      pos_q  <= '0;
      wrap_q <= 1'b0;
      fill_q <= 1'b0;
      fwd_q  <= 1'b0;
    end else if (ctrl_i.rd) begin
      pos_q  <= pos_d;
      wrap_q <= wrap_q | pos_wrap;
      fill_q <= wrap_q;
      // A one-entry line reads the entry that the previous request writes now.
      fwd_q  <= ctrl_i.wr && (addr_q == pos_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      mem_rd_q   <= mem[pos_q];
      addr_q     <= pos_q;
      fwd_data_q <= wdata_i;
    end
    if (ctrl_i.wr) begin
      mem[addr_q] <= wdata_i;
    end
  end

  // Entries not yet written since the last clear read as zero.
  assign rdata_o = fwd_q  ? fwd_data_q :
                   fill_q ? mem_rd_q   : '0;

endmodule

@@ rtl/core/scr_hpf.sv @@
`timescale 1ns / 1ps
// Echo high-pass: 32-tap delay of half the echo minus a 64-tap moving sum
// of echo/128. Depends on scr_pkg for the control struct and asr32.
module scr_hpf import scr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scr_ctrl_t         ctrl_i,
  input  logic [DATA_W-1:0] echo_i,
  output logic [DATA_W-1:0] echodly_o
);

  localparam int DLY_AW = $clog2(HP_DLY_DEPTH);
  localparam int AVG_AW = $clog2(HP_AVG_DEPTH);

  logic [DATA_W-1:0] dly_mem [HP_DLY_DEPTH];
  logic [DATA_W-1:0] avg_mem [HP_AVG_DEPTH];
  logic [DATA_W-1:0] dly_rd_q, avg_rd_q;
  logic [DLY_AW-1:0] dly_pos_q, dly_addr_q;
  logic [AVG_AW-1:0] avg_pos_q, avg_addr_q;
  logic              dly_wrap_q, avg_wrap_q, dly_fill_q, avg_fill_q;
  logic [DATA_W-1:0] sum_q, sum_d;
  logic [DATA_W-1:0] dly_val, avg_val, rnd, quot;

  always_comb begin
    dly_val = dly_fill_q ? dly_rd_q : '0;
    avg_val = avg_fill_q ? avg_rd_q : '0;
    // Division by 128 truncating toward zero: bias negative values first.
    rnd     = echo_i + (echo_i[DATA_W-1] ? DATA_W'(127) : '0);
    quot    = asr32(rnd, 3'd7);
    sum_d   = sum_q - avg_val + quot;
  end

  assign echodly_o = dly_val - sum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dly_pos_q  <= '0;
      avg_pos_q  <= '0;
      dly_wrap_q <= 1'b0;
      avg_wrap_q <= 1'b0;
      dly_fill_q <= 1'b0;
      avg_fill_q <= 1'b0;
      sum_q      <= '0;
    end else if (ctrl_i.clr) begin
      dly_pos_q  <= '0;
      avg_pos_q  <= '0;
      dly_wrap_q <= 1'b0;
      avg_wrap_q <= 1'b0;
      dly_fill_q <= 1'b0;
      avg_fill_q <= 1'b0;
      sum_q      <= '0;
    end else begin
      if (ctrl_i.rd) begin
        dly_pos_q  <= dly_pos_q + 1'b1;
        avg_pos_q  <= avg_pos_q + 1'b1;
        dly_wrap_q <= dly_wrap_q | (dly_pos_q == '1);
        avg_wrap_q <= avg_wrap_q | (avg_pos_q == '1);
        dly_fill_q <= dly_wrap_q;
        avg_fill_q <= avg_wrap_q;
      end
      if (ctrl_i.wr) begin
        sum_q <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      dly_rd_q   <= dly_mem[dly_pos_q];
      avg_rd_q   <= avg_mem[avg_pos_q];
      dly_addr_q <= dly_pos_q;
      avg_addr_q <= avg_pos_q;
    end
    if (ctrl_i.wr) begin
      dly_mem[dly_addr_q] <= asr32(echo_i, 3'd1);
      avg_mem[avg_addr_q] <= quot;
    end
  end

endmodule

@@ tb/stereo_comb_reverb_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for stereo_comb_reverb: directed table, then random phases.
// Depends on scr_pkg and the stereo_comb_reverb RTL only.
module stereo_comb_reverb_tb;
  import scr_pkg::*;

  localparam int          PHASES        = 10;
  localparam int          PHASE_ITEMS   = 75;
  localparam int          DRAIN_CYCLES  = 10;
  localparam int          LIMIT_CYCLES  = 200000;
  localparam int          PRED_DEPTH_A  = LINE_A_DEPTH_DEF;
  localparam int          PRED_DEPTH_B  = LINE_B_DEPTH_DEF;
  localparam int          PRED_DEPTH_C  = LINE_C_DEPTH_DEF;
  localparam int          PRED_DEPTH_D  = LINE_D_DEPTH_DEF;
  localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;
  // Register index past the end of the list; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  // One step of the directed table. For a sample row with fixed set, the result
  // is the exp_* pair typed in below; otherwise the predictor supplies it.
  typedef struct packed {
    row_kind_e                   kind;
    logic [CFG_IDX_W-1:0]        reg_idx;
    logic [CFG_DATA_W-1:0]       wdata;
    logic signed [SAMPLE_W-1:0]  first;
    logic signed [SAMPLE_W-1:0]  second;
    logic                        blk_end;
    logic                        fixed;
    logic signed [SAMPLE_W-1:0]  exp_first;
    logic signed [SAMPLE_W-1:0]  exp_second;
  } dir_row_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] first;
    logic signed [SAMPLE_W-1:0] second;
    logic                       blk_end;
  } sample_pair_t;

  // The directed part. Expectations are typed in only where the echo is still
  // zero (early requests after reset or after a clearing write, before any line
  // refills) or where the block is bypassed, so the output simply equals the input.
  localparam int DIR_ROWS = 34;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // Reset settings: extremes of both channels and of the block end mark.
    '{ROW_SAMPLE, CFG_ENABLE, 16'd0, S_MAX, S_MIN, 1'b1, 1'b1, S_MAX, S_MIN},
    '{ROW_SAMPLE, CFG_ENABLE, 16'd0, S_MIN, S_MAX, 1'b0, 1'b1, S_MIN, S_MAX},
    '{ROW_SAMPLE, CFG_ENABLE, 16'd0, 16'sd0, 16'sd0, 1'b1, 1'b1, 16'sd0, 16'sd0},
    '{ROW_SAMPLE, CFG_ENABLE, 16'd0, -16'sd1, 16'sd1, 1'b0, 1'b1, -16'sd1, 16'sd1},
    // Bypass: samples pass through untouched.
    '{ROW_WRITE, CFG_ENABLE, 16'd0, '0, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_SAMPLE, CFG_ENABLE, 16'd0, S_MAX, S_MAX, 1'b1, 1'b1, S_MAX, S_MAX},
    '{ROW_SAMPLE, CFG_ENABLE, 16'd0, S_MIN, S_MIN, 1'b0, 1'b1, S_MIN, S_MIN},
    '{ROW_SAMPLE, CFG_ENABLE, 16'd0, 16'sd4660, -16'sd17185, 1'b1, 1'b1,
      16'sd4660, -16'sd17185},
    // Reverb back on, no attenuation, every line one sample long.
    '{ROW_WRITE, CFG_ENABLE, 16'd1, '0, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_WRITE, CFG_ATTN,   16'd0, '0, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_WRITE, CFG_LEN_A,  16'd1, '0, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_WRITE, CFG_LEN_B,  16'd1, '0, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_WRITE, CFG_LEN_C,  16'd1, '0, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_WRITE, CFG_LEN_D,  16'd1, '0, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_SAMPLE, CFG_ENABLE, 16'd0, S_MAX, S_MAX, 1'b0, 1'b1, S_MAX, S_MAX},
    '{ROW_SAMPLE, CFG_ENABLE, 16'd0, S_MAX, S_MAX, 1'b1, 1'b0, '0, '0},
    '{ROW_SAMPLE, CFG_ENABLE, 16'd0, S_MIN, S_MIN, 1'b0, 1'b0, '0, '0},
    '{ROW_SAMPLE, CFG_ENABLE, 16'd0, S_MAX, S_MIN, 1'b1, 1'b0, '0, '0},
    '{ROW_SAMPLE, CFG_ENABLE, 16'd0, 16'sd0, 16'sd0, 1'b0, 1'b0, '0, '0},
    // Largest attenuation code and zero length on every line.
    '{ROW_WRITE, CFG_ATTN,   16'd7, '0, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_WRITE, CFG_LEN_A,  16'd0, '0, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_WRITE, CFG_LEN_B,  16'd0, '0, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_WRITE, CFG_LEN_C,  16'd0, '0, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_WRITE, CFG_LEN_D,  16'd0, '0, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_SAMPLE, CFG_ENABLE, 16'd0, S_MIN, S_MIN, 1'b1, 1'b1, S_MIN, S_MIN},
    '{ROW_SAMPLE, CFG_ENABLE, 16'd0, S_MIN, S_MIN, 1'b0, 1'b0, '0, '0},
    '{ROW_SAMPLE, CFG_ENABLE, 16'd0, S_MAX, S_MAX, 1'b1, 1'b0, '0, '0},
    // Attenuation six, lengths past the line depths (all field bits set on a).
    '{ROW_WRITE, CFG_ATTN,   16'd6,     '0, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_WRITE, CFG_LEN_A,  16'd32767, '0, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_WRITE, CFG_LEN_B,  16'd16385, '0, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_WRITE, CFG_LEN_C,  16'd16383, '0, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_WRITE, CFG_LEN_D,  16'd8191,  '0, '0, 1'b0, 1'b0, '0, '0},
    '{ROW_SAMPLE, CFG_ENABLE, 16'd0, S_MAX, S_MAX, 1'b0, 1'b1, S_MAX, S_MAX},
    // A write to an unused index must neither apply nor clear anything.
    '{ROW_WRITE, CFG_SPARE,  16'hFFFF, '0, '0, 1'b0, 1'b0, '0, '0}
  };

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]      cfg_data_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic signed [SAMPLE_W-1:0] first_channel_in_i = '0;
  logic signed [SAMPLE_W-1:0] second_channel_in_i = '0;
  logic                       block_end_in_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic signed [SAMPLE_W-1:0] first_channel_out_o;
  logic signed [SAMPLE_W-1:0] second_channel_out_o;
  logic                       block_end_out_o;

  // Percent chance per cycle that the sender leaves a gap or the receiver stalls.
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // Output pairs predicted for requests already accepted, oldest first.
  sample_pair_t expected_pairs[$];

  // Predictor copy of the registers and of every piece of filter state.
  logic        en_q;
  int unsigned attn_q;
  int unsigned len_a_q, len_b_q, len_c_q, len_d_q;
  int          fb_a [PRED_DEPTH_A];
  int          fb_b [PRED_DEPTH_B];
  int          fb_c [PRED_DEPTH_C];
  int          fb_d [PRED_DEPTH_D];
  int unsigned pos_a, pos_b, pos_c, pos_d;
  int          hp_tap [HP_DLY_DEPTH];
  int unsigned hp_pos;
  int          dc_store [HP_AVG_DEPTH];
  int          dc_sum;
  int unsigned dc_pos;
  int          smooth_store [LP_DEPTH];
  int          smooth_sum;
  int unsigned smooth_pos;

  stereo_comb_reverb DUT (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .first_channel_in_i   (first_channel_in_i),
    .second_channel_in_i  (second_channel_in_i),
    .block_end_in_i       (block_end_in_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .first_channel_out_o  (first_channel_out_o),
    .second_channel_out_o (second_channel_out_o),
    .block_end_out_o      (block_end_out_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // The receiver draws a fresh stall decision every cycle.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Every write to a listed register wipes the delay lines, the filters and the positions.
  function automatic void wipe_filter_state();
    foreach (fb_a[i]) fb_a[i] = 0;
    foreach (fb_b[i]) fb_b[i] = 0;
    foreach (fb_c[i]) fb_c[i] = 0;
    foreach (fb_d[i]) fb_d[i] = 0;
    foreach (hp_tap[i]) hp_tap[i] = 0;
    foreach (dc_store[i]) dc_store[i] = 0;
    foreach (smooth_store[i]) smooth_store[i] = 0;
    pos_a = 0;
    pos_b = 0;
    pos_c = 0;
    pos_d = 0;
    hp_pos = 0;
    dc_sum = 0;
    dc_pos = 0;
    smooth_sum = 0;
    smooth_pos = 0;
  endfunction

  function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
    logic known;
    known = 1'b1;
    case (idx)
      CFG_ENABLE: en_q = data[0];
      CFG_ATTN:   attn_q = 32'(data[ATTN_W-1:0]);
      CFG_LEN_A:  len_a_q = 32'(data[LEN_A_W-1:0]);
      CFG_LEN_B:  len_b_q = 32'(data[LEN_B_W-1:0]);
      CFG_LEN_C:  len_c_q = 32'(data[LEN_C_W-1:0]);
      CFG_LEN_D:  len_d_q = 32'(data[LEN_D_W-1:0]);
      default:    known = 1'b0;
    endcase
    if (known) wipe_filter_state();
  endfunction

  // A length of zero behaves as one; a length beyond the line uses the whole line.
  function automatic int unsigned next_pos(input int unsigned pos, input int unsigned len,
                                           input int unsigned depth);
    int unsigned lim;
    int unsigned nxt;
    lim = (len > depth) ? depth : len;
    nxt = pos + 1;
    if (nxt >= lim || nxt >= depth) nxt = 0;
    return nxt;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] clamp16(input longint v);
    if (v > 32767) return S_MAX;
    if (v < -32768) return S_MIN;
    return SAMPLE_W'(v);
  endfunction

  // Works out the output pair of one sample pair and advances the filter state.
  // All sums wrap at 32 bits as int does, and >>> on int is arithmetic.
  task automatic reverb_predict(input logic signed [SAMPLE_W-1:0] x0, x1,
                                input logic be, output sample_pair_t res);
    int echo;
    int dly;
    int frac;
    int mix;
    res.first   = x0;
    res.second  = x1;
    res.blk_end = be;
    if (en_q) begin
      echo = fb_a[pos_a] + fb_b[pos_b] + fb_c[pos_c] + fb_d[pos_d];
      // High-pass: half the echo through a 32-tap delay, minus a 64-tap sum of
      // echo/128. Division on int truncates toward zero.
      dly = hp_tap[hp_pos];
      hp_tap[hp_pos] = echo >>> 1;
      hp_pos = (hp_pos + 1) % HP_DLY_DEPTH;
      frac = echo / 128;
      dc_sum = dc_sum - dc_store[dc_pos] + frac;
      dc_store[dc_pos] = frac;
      dc_pos = (dc_pos + 1) % HP_AVG_DEPTH;
      dly = dly - dc_sum;
      res.first  = clamp16(longint'(x0) + longint'(dly));
      res.second = clamp16(longint'(x1) + longint'(dly));
      // Lines c and d take the attenuated mono input plus a quarter of the echo.
      mix = ((int'(x0) + int'(x1)) >>> attn_q) + (dly >>> 2);
      fb_c[pos_c] = mix;
      fb_d[pos_d] = mix;
      // Lines a and b take that mix plus an eighth of the echo, smoothed by an 8-tap moving average.
      mix = (mix + (dly >>> 3)) >>> 1;
      smooth_sum = smooth_sum - smooth_store[smooth_pos] + mix;
      smooth_store[smooth_pos] = mix;
      smooth_pos = (smooth_pos + 1) % LP_DEPTH;
      fb_a[pos_a] = smooth_sum >>> 2;
      fb_b[pos_b] = smooth_sum >>> 2;
      pos_a = next_pos(pos_a, len_a_q, PRED_DEPTH_A);
      pos_b = next_pos(pos_b, len_b_q, PRED_DEPTH_B);
      pos_c = next_pos(pos_c, len_c_q, PRED_DEPTH_C);
      pos_d = next_pos(pos_d, len_d_q, PRED_DEPTH_D);
    end
  endtask

  // Register writes happen only with nothing in flight. Valid is left high on
  // return so that back-to-back writes never lower and raise it in one step;
  // whoever drives next lowers it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    in_valid_i <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_write(idx, data);
  endtask

  // Sends one sample request, with random gaps in front of it, and files the
  // expected output pair once the block has taken the request.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] first, second,
                             input logic be, input logic fixed,
                             input logic signed [SAMPLE_W-1:0] exp_first, exp_second);
    sample_pair_t predicted;
    cfg_valid_i <= 1'b0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i          <= 1'b1;
    first_channel_in_i  <= first;
    second_channel_in_i <= second;
    block_end_in_i      <= be;
    do @(posedge clk_i); while (!in_ready_o);
    reverb_predict(first, second, be, predicted);
    if (fixed) begin
      predicted.first  = exp_first;
      predicted.second = exp_second;
    end
    expected_pairs.push_back(predicted);
  endtask

  // Field value with random junk above the register width, which the block must ignore.
  function automatic logic [CFG_DATA_W-1:0] cfg_word(input int unsigned value,
                                                     input int unsigned width);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom());
    return (junk << width) | CFG_DATA_W'(value);
  endfunction

  // Sample mix: full range, quiet, clipped, and moderate levels.
  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(3))
      0:       return SAMPLE_W'($urandom());
      1:       return SAMPLE_W'(int'($urandom_range(2000)) - 1000);
      2:       return $urandom_range(1) ? S_MAX : S_MIN;
      default: return SAMPLE_W'(int'($urandom_range(16000)) - 8000);
    endcase
  endfunction

  // Output checker: each accepted output pair is matched against the oldest
  // prediction. Sampling at the edge sees values from before the edge, since
  // both sides drive with nonblocking assignments.
  always @(posedge clk_i) begin : out_check
    sample_pair_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pairs.size() == 0) begin
        $display("%0t: output with nothing expected: actual %0d %0d %0b", $time,
                 first_channel_out_o, second_channel_out_o, block_end_out_o);
        mismatch_count++;
      end else begin
        want = expected_pairs.pop_front();
        if (first_channel_out_o !== want.first || second_channel_out_o !== want.second ||
            block_end_out_o !== want.blk_end) begin
          $display("%0t: mismatch: expected %0d %0d %0b, actual %0d %0d %0b", $time,
                   want.first, want.second, want.blk_end,
                   first_channel_out_o, second_channel_out_o, block_end_out_o);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int unsigned la, lb, lc, ld, attn, enable;
    // Predictor starts from the reset register values with all state cleared.
    en_q    = 1'b1;
    attn_q  = 32'(ATTN_RESET);
    len_a_q = 32'(LEN_A_RESET);
    len_b_q = 32'(LEN_B_RESET);
    len_c_q = 32'(LEN_C_RESET);
    len_d_q = 32'(LEN_D_RESET);
    wipe_filter_state();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table under light idling on both sides.
    gap_pct   = 27;
    stall_pct = 27;
    foreach (DIR_TABLE[i]) begin
      if (DIR_TABLE[i].kind == ROW_WRITE) begin
        write_reg(DIR_TABLE[i].reg_idx, DIR_TABLE[i].wdata);
      end else begin
        send_sample(DIR_TABLE[i].first, DIR_TABLE[i].second, DIR_TABLE[i].blk_end,
                    DIR_TABLE[i].fixed, DIR_TABLE[i].exp_first, DIR_TABLE[i].exp_second);
      end
    end
    // Runs on after the unused-index write to show the state survived it.
    send_sample(16'sd12345, -16'sd12345, 1'b0, 1'b0, '0, '0);
    send_sample(S_MIN, S_MAX, 1'b1, 1'b0, '0, '0);

    // Random phases. Each one picks a register setting and an idling pattern;
    // short lines dominate so that the feedback builds up within a phase.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct   = 52;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 52;
        end
        default: begin
          gap_pct   = 27;
          stall_pct = 27;
        end
      endcase

      enable = (phase != 3) ? 1 : 0;
      case (phase)
        1:       attn = 1;
        2:       attn = 5;
        6:       attn = $urandom_range(1) ? 0 : $urandom_range(7, 6);
        default: attn = $urandom_range(5, 1);
      endcase
      case (phase)
        4: begin
          // Longest lengths in the nominal range.
          la = 16384;
          lb = 16384;
          lc = 8192;
          ld = 4096;
        end
        7: begin
          // Anything the fields can hold, often beyond the line depths.
          la = $urandom_range((1 << LEN_A_W) - 1);
          lb = $urandom_range((1 << LEN_B_W) - 1);
          lc = $urandom_range((1 << LEN_C_W) - 1);
          ld = $urandom_range((1 << LEN_D_W) - 1);
        end
        9: begin
          la = 1;
          lb = 1;
          lc = 1;
          ld = 1;
        end
        default: begin
          // Short lines in the usual 13/17, 7/13 and 7/19 ratios.
          la = $urandom_range(64, 4);
          lb = (la * 13) / 17;
          lc = (la * 7) / 13;
          ld = (la * 7) / 19;
        end
      endcase
      write_reg(CFG_ENABLE, cfg_word(enable, 1));
      write_reg(CFG_ATTN,   cfg_word(attn, ATTN_W));
      write_reg(CFG_LEN_A,  cfg_word(la, LEN_A_W));
      write_reg(CFG_LEN_B,  cfg_word(lb, LEN_B_W));
      write_reg(CFG_LEN_C,  cfg_word(lc, LEN_C_W));
      write_reg(CFG_LEN_D,  cfg_word(ld, LEN_D_W));

      repeat (PHASE_ITEMS) begin
        send_sample(rand_sample(), rand_sample(), 1'($urandom_range(1)), 1'b0, '0, '0);
      end
    end

    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk_i);
    // A few more cycles so that a stray extra output would still be caught.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
